[hw/rtl/nmk_pkg.sv]
// Shared types, constants and microcode for the Newmark-beta SDOF integrator.
package nmk_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned PCW = 6;
  localparam int unsigned QW = DW + FB;

  localparam logic [DW-1:0] ONE_Q = DW'(1) << FB;
  localparam logic [DW-1:0] HALF_Q = DW'(1) << (FB - 1);
  localparam logic [PCW-1:0] START_PC = PCW'(28);

  typedef enum logic [2:0] {
    CFG_MASS, CFG_DAMP, CFG_STIFF, CFG_GAMMA, CFG_BETA, CFG_DT, CFG_SDISP, CFG_SVEL
  } cfg_idx_e;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_e;

  typedef enum logic [4:0] {
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6, SRC_T7,
    SRC_F, SRC_M, SRC_C, SRC_K, SRC_G, SRC_BT, SRC_DT, SRC_ONE, SRC_HALF,
    SRC_U, SRC_V, SRC_A, SRC_SD, SRC_SV, SRC_ZERO
  } src_e;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_ISSUE, S_WAIT, S_OUT} seq_state_e;
  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} alu_state_e;

  typedef struct packed {
    op_e  op;
    src_e dst;
    src_e sa;
    src_e sb;
    logic last;
  } uop_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  function automatic uop_t uop(op_e op, src_e dst, src_e sa, src_e sb, logic last);
    uop_t u;
    u.op = op; u.dst = dst; u.sa = sa; u.sb = sb; u.last = last;
    return u;
  endfunction

  // step program at 0..27, start program at START_PC..34
  function automatic uop_t prog(logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = uop(OP_SUB, SRC_T0, SRC_HALF, SRC_BT, 1'b0);
      6'd1:  u = uop(OP_MUL, SRC_T0, SRC_T0, SRC_A, 1'b0);
      6'd2:  u = uop(OP_MUL, SRC_T0, SRC_DT, SRC_T0, 1'b0);
      6'd3:  u = uop(OP_ADD, SRC_T0, SRC_V, SRC_T0, 1'b0);
      6'd4:  u = uop(OP_MUL, SRC_T0, SRC_DT, SRC_T0, 1'b0);
      6'd5:  u = uop(OP_ADD, SRC_T0, SRC_U, SRC_T0, 1'b0);
      6'd6:  u = uop(OP_SUB, SRC_T1, SRC_ONE, SRC_G, 1'b0);
      6'd7:  u = uop(OP_MUL, SRC_T1, SRC_T1, SRC_A, 1'b0);
      6'd8:  u = uop(OP_MUL, SRC_T1, SRC_DT, SRC_T1, 1'b0);
      6'd9:  u = uop(OP_ADD, SRC_T1, SRC_V, SRC_T1, 1'b0);
      6'd10: u = uop(OP_MUL, SRC_T2, SRC_BT, SRC_K, 1'b0);
      6'd11: u = uop(OP_MUL, SRC_T2, SRC_DT, SRC_T2, 1'b0);
      6'd12: u = uop(OP_MUL, SRC_T3, SRC_G, SRC_C, 1'b0);
      6'd13: u = uop(OP_ADD, SRC_T2, SRC_T3, SRC_T2, 1'b0);
      6'd14: u = uop(OP_MUL, SRC_T2, SRC_DT, SRC_T2, 1'b0);
      6'd15: u = uop(OP_ADD, SRC_T2, SRC_M, SRC_T2, 1'b0);
      6'd16: u = uop(OP_MUL, SRC_T3, SRC_C, SRC_T1, 1'b0);
      6'd17: u = uop(OP_SUB, SRC_T3, SRC_F, SRC_T3, 1'b0);
      6'd18: u = uop(OP_MUL, SRC_T4, SRC_K, SRC_T0, 1'b0);
      6'd19: u = uop(OP_SUB, SRC_T3, SRC_T3, SRC_T4, 1'b0);
      6'd20: u = uop(OP_DIV, SRC_A, SRC_T3, SRC_T2, 1'b0);
      6'd21: u = uop(OP_MUL, SRC_T5, SRC_BT, SRC_A, 1'b0);
      6'd22: u = uop(OP_MUL, SRC_T5, SRC_DT, SRC_T5, 1'b0);
      6'd23: u = uop(OP_MUL, SRC_T5, SRC_DT, SRC_T5, 1'b0);
      6'd24: u = uop(OP_ADD, SRC_U, SRC_T0, SRC_T5, 1'b0);
      6'd25: u = uop(OP_MUL, SRC_T5, SRC_G, SRC_A, 1'b0);
      6'd26: u = uop(OP_MUL, SRC_T5, SRC_DT, SRC_T5, 1'b0);
      6'd27: u = uop(OP_ADD, SRC_V, SRC_T1, SRC_T5, 1'b1);
      6'd28: u = uop(OP_MUL, SRC_T0, SRC_C, SRC_SV, 1'b0);
      6'd29: u = uop(OP_SUB, SRC_T1, SRC_F, SRC_T0, 1'b0);
      6'd30: u = uop(OP_MUL, SRC_T2, SRC_K, SRC_SD, 1'b0);
      6'd31: u = uop(OP_SUB, SRC_T1, SRC_T1, SRC_T2, 1'b0);
      6'd32: u = uop(OP_DIV, SRC_A, SRC_T1, SRC_M, 1'b0);
      6'd33: u = uop(OP_ADD, SRC_U, SRC_SD, SRC_ZERO, 1'b0);
      6'd34: u = uop(OP_ADD, SRC_V, SRC_SV, SRC_ZERO, 1'b1);
      default: u = uop(OP_ADD, SRC_T7, SRC_ZERO, SRC_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/nmk_alu.sv]
// Shared saturating Q16.16 add/sub, multiply and bit-serial divide unit.
module nmk_alu import nmk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alu_req_t      req_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] res_o,
  output logic          sat_o
);

  localparam int unsigned CW = $clog2(QW);

  alu_state_e      state_q, state_d;
  logic            done_q, done_d;
  logic [DW-1:0]   res_q, res_d;
  logic            sat_q, sat_d;
  logic            neg_q, neg_d;
  logic [2*DW-1:0] prod_q, prod_d;
  logic [QW-1:0]   num_q, num_d;
  logic [DW-1:0]   rem_q, rem_d, den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic [DW-1:0] mag_a, mag_b;
  logic [DW:0]   sum;
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW:0]   fin;

  // {sat, value} from sign and magnitude, clipped to the signed range
  function automatic logic [DW:0] finish(logic neg, logic [QW-1:0] m);
    logic [QW-1:0] lim;
    logic [DW-1:0] v;
    lim = neg ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
    v = m[DW-1:0];
    if (m > lim) begin
      return {1'b1, neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}}};
    end
    return {1'b0, neg ? (~v + DW'(1)) : v};
  endfunction

  assign mag_a = a_i[DW-1] ? (~a_i + DW'(1)) : a_i;
  assign mag_b = b_i[DW-1] ? (~b_i + DW'(1)) : b_i;
  assign sum = (req_i.op == OP_SUB) ? ({a_i[DW-1], a_i} - {b_i[DW-1], b_i})
                                    : ({a_i[DW-1], a_i} + {b_i[DW-1], b_i});
  assign rem_sh = {rem_q, num_q[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign fin = finish(neg_q, (state_q == A_MUL) ? prod_q[2*DW-1-(2*DW-QW-FB) -: QW]
                                                : num_q);

  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    res_d = res_q;
    sat_d = 1'b0;
    neg_d = neg_q;
    prod_d = prod_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_d = a_i[DW-1] ^ b_i[DW-1];
          case (req_i.op)
            OP_ADD, OP_SUB: begin
              done_d = 1'b1;
              if (sum[DW] != sum[DW-1]) begin
                sat_d = 1'b1;
                res_d = {sum[DW], {(DW-1){~sum[DW]}}};
              end else begin
                res_d = sum[DW-1:0];
              end
            end
            OP_MUL: begin
              prod_d = mag_a * mag_b;
              state_d = A_MUL;
            end
            OP_DIV: begin
              if (b_i == '0) begin
                done_d = 1'b1;
                sat_d = 1'b1;
                if (a_i == '0) res_d = '0;
                else res_d = {a_i[DW-1], {(DW-1){~a_i[DW-1]}}};
              end else begin
                num_d = {mag_a, {FB{1'b0}}};
                rem_d = '0;
                den_d = mag_b;
                cnt_d = CW'(QW - 1);
                state_d = A_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      A_MUL: begin
        // product keeps FB fraction bits too many; prod_q[2*DW-1:FB] is the result magnitude
        {sat_d, res_d} = fin;
        done_d = 1'b1;
        state_d = A_IDLE;
      end
      A_DIV: begin
        rem_d = rem_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
        num_d = {num_q[QW-2:0], rem_ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          {sat_d, res_d} = finish(neg_q, {num_q[QW-2:0], rem_ge});
          done_d = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    neg_q <= neg_d;
    prod_q <= prod_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == A_MUL) |=> done_q && state_q == A_IDLE)
    else $error("multiply did not finish in one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) != A_IDLE || $past(req_i.start))
    else $error("done without a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == A_DIV && cnt_q != '0) |=> state_q == A_DIV && !done_q)
    else $error("divide ended early");

endmodule

[hw/rtl/sdof_newmark_integrator_core.sv]
// Top level: microcode sequencer, temporaries, state and stream ports.
// A start request runs 7 micro-ops, a step request 28; divide makes one quotient bit per
// cycle over 48 bits, and a zero divisor skips the bit-serial loop and saturates.
// The result waits while the output register is held; one request is in flight at a time,
// since the input is accepted only while the sequencer is idle.
// Reset (async, active low) clears state to zero, loads register defaults, empties output.
module sdof_newmark_integrator_core import nmk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [DW-1:0] cfg_wdata_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,   // [31:0] force_sample
  input  logic          s_axis_tuser_i,   // [0] start_req
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [95:0]   m_axis_tdata_o,   // [31:0] disp_out, [63:32] vel_out, [95:64] accel_out
  output logic          m_axis_tuser_o    // [0] saturated
);

  seq_state_e state_q, state_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic [DW-2:0] mass_q, gamma_q, beta_q, dt_q;
  logic [DW-1:0] damp_q, stiff_q, sdisp_q, svel_q;
  logic [DW-1:0] force_q, u_q, v_q, a_q;
  logic sat_q;
  logic out_valid_q;
  logic [95:0] out_data_q;
  logic out_sat_q;

  logic [DW-1:0] tmp_mem [8];
  logic [DW-1:0] rd_a_q, rd_b_q;

  uop_t cur;
  alu_req_t alu_req;
  logic alu_done, alu_sat;
  logic [DW-1:0] alu_res, opa, opb;
  logic in_acc, out_free;

  assign cur = prog(pc_q);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  function automatic logic [DW-1:0] src_val(src_e s, logic [DW-1:0] rd,
      logic [DW-1:0] f, logic [DW-2:0] m, logic [DW-1:0] c, logic [DW-1:0] k,
      logic [DW-2:0] g, logic [DW-2:0] bt, logic [DW-2:0] dt, logic [DW-1:0] u,
      logic [DW-1:0] v, logic [DW-1:0] a, logic [DW-1:0] sd, logic [DW-1:0] sv);
    case (s)
      SRC_F:    return f;
      SRC_M:    return {1'b0, m};
      SRC_C:    return c;
      SRC_K:    return k;
      SRC_G:    return {1'b0, g};
      SRC_BT:   return {1'b0, bt};
      SRC_DT:   return {1'b0, dt};
      SRC_ONE:  return ONE_Q;
      SRC_HALF: return HALF_Q;
      SRC_U:    return u;
      SRC_V:    return v;
      SRC_A:    return a;
      SRC_SD:   return sd;
      SRC_SV:   return sv;
      SRC_ZERO: return '0;
      default:  return rd;
    endcase
  endfunction

  assign opa = src_val(cur.sa, rd_a_q, force_q, mass_q, damp_q, stiff_q, gamma_q, beta_q,
                       dt_q, u_q, v_q, a_q, sdisp_q, svel_q);
  assign opb = src_val(cur.sb, rd_b_q, force_q, mass_q, damp_q, stiff_q, gamma_q, beta_q,
                       dt_q, u_q, v_q, a_q, sdisp_q, svel_q);

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_FETCH;
          pc_d = s_axis_tuser_i ? START_PC : '0;
        end
      end
      S_FETCH: state_d = S_ISSUE;
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (alu_done) begin
          if (cur.last) state_d = S_OUT;
          else begin
            state_d = S_FETCH;
            pc_d = pc_q + PCW'(1);
          end
        end
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    alu_req.start = (state_q == S_ISSUE);
    alu_req.op = cur.op;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  nmk_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (alu_done),
    .res_o  (alu_res),
    .sat_o  (alu_sat)
  );

  // temporaries: one write port, two registered reads
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && alu_done && !cur.dst[4] && !cur.dst[3]) begin
      tmp_mem[cur.dst[2:0]] <= alu_res;
    end
    if (state_q == S_FETCH) begin
      rd_a_q <= tmp_mem[cur.sa[2:0]];
      rd_b_q <= tmp_mem[cur.sb[2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) force_q <= s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      mass_q <= (DW-1)'(65536);
      damp_q <= '0;
      stiff_q <= DW'(65536);
      gamma_q <= (DW-1)'(32768);
      beta_q <= (DW-1)'(16384);
      dt_q <= (DW-1)'(655);
      sdisp_q <= '0;
      svel_q <= '0;
      u_q <= '0;
      v_q <= '0;
      a_q <= '0;
      sat_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
      out_sat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MASS:  mass_q <= cfg_wdata_i[DW-2:0];
          CFG_DAMP:  damp_q <= cfg_wdata_i;
          CFG_STIFF: stiff_q <= cfg_wdata_i;
          CFG_GAMMA: gamma_q <= cfg_wdata_i[DW-2:0];
          CFG_BETA:  beta_q <= cfg_wdata_i[DW-2:0];
          CFG_DT:    dt_q <= cfg_wdata_i[DW-2:0];
          CFG_SDISP: sdisp_q <= cfg_wdata_i;
          CFG_SVEL:  svel_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) sat_q <= 1'b0;
      else if (state_q == S_WAIT && alu_done) begin
        sat_q <= sat_q | alu_sat;
        case (cur.dst)
          SRC_U:   u_q <= alu_res;
          SRC_V:   v_q <= alu_res;
          SRC_A:   a_q <= alu_res;
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q <= {a_q, v_q, u_q};
        out_sat_q <= sat_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_FETCH)
    else $error("request accepted but sequencer did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == S_WAIT)
    else $error("ALU result outside wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded into output register");

endmodule
